// ----- rtl/text_mode_console_writer_macros.svh -----
// ----------------------------------------------------------------------------
// Console writer assertion macros
// Shorthand for the clocked checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_CONSOLE_WRITER_MACROS_SVH
`define TEXT_MODE_CONSOLE_WRITER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define TMCW_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("console writer: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define TMCW_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("console writer: next-cycle check failed");

`endif

// ----- rtl/tmcw_pkg.sv -----
// ----------------------------------------------------------------------------
// Console writer package
// Field widths, action and byte codes, and the command passed front to back.
// ----------------------------------------------------------------------------
package tmcw_pkg;

  localparam int ACT_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  // Row of a grid cell; grids go up to 64 rows.
  localparam int CELL_ROW_W = 6;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUT    = 2'd0,
    ACT_LOCATE = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    LEAD_NONE = 2'd0,
    LEAD_D0   = 2'd1,
    LEAD_D1   = 2'd2,
    LEAD_ESC  = 2'd3
  } lead_t;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_LEAD_D0  = 8'hD0;
  localparam logic [7:0] CH_LEAD_D1  = 8'hD1;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_YO_UP    = 8'h81;
  localparam logic [7:0] CP_YO_UP    = 8'hF0;
  localparam logic [7:0] OFS_D0      = 8'h10;
  localparam logic [7:0] CH_YO_LOW   = 8'h91;
  localparam logic [7:0] CP_YO_LOW   = 8'hF1;
  localparam logic [7:0] D1_SPLIT    = 8'hB0;
  localparam logic [7:0] OFS_D1_LOW  = 8'h60;
  localparam logic [7:0] OFS_D1_HIGH = 8'h10;
  localparam logic [7:0] ATTR_RESET  = 8'h07;

  // One request, classified: what the memory side does and the cursor to report.
  typedef struct packed {
    logic                  wr_cell;
    logic                  scroll;
    logic                  clear;
    logic                  rd_cell;
    logic [CELL_ROW_W-1:0] row;
    logic [COL_W-1:0]      col;
    logic [BYTE_W-1:0]     ch;
    logic [BYTE_W-1:0]     attr;
    logic [COL_W-1:0]      cur_col;
    logic [ROW_W-1:0]      cur_row;
  } cmd_t;

endpackage

// ----- rtl/tmcw_if.sv -----
// ----------------------------------------------------------------------------
// Console writer channels
// Request, response and margin-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tmcw_in_if;
  logic                           valid;
  logic                           ready;
  logic [tmcw_pkg::ACT_W-1:0]     action;
  logic [tmcw_pkg::BYTE_W-1:0]    data_byte;
  logic [tmcw_pkg::COL_W-1:0]     col_in;
  logic [tmcw_pkg::ROW_W-1:0]     row_in;
  modport source (output valid, action, data_byte, col_in, row_in, input ready);
  modport sink (input valid, action, data_byte, col_in, row_in, output ready);
endinterface

interface tmcw_out_if;
  logic                           valid;
  logic                           ready;
  logic [tmcw_pkg::COL_W-1:0]     cursor_col;
  logic [tmcw_pkg::ROW_W-1:0]     cursor_row;
  logic [tmcw_pkg::BYTE_W-1:0]    cell_char;
  logic [tmcw_pkg::BYTE_W-1:0]    cell_attr;
  modport source (output valid, cursor_col, cursor_row, cell_char, cell_attr, input ready);
  modport sink (input valid, cursor_col, cursor_row, cell_char, cell_attr, output ready);
endinterface

interface tmcw_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tmcw_pkg::COL_W-1:0]     left_margin;
  modport source (output valid, left_margin, input ready);
  modport sink (input valid, left_margin, output ready);
endinterface

// ----- rtl/tmcw_front.sv -----
// ----------------------------------------------------------------------------
// Console writer front end
// Decodes each request, tracks cursor, attribute and lead byte, emits commands.
// ----------------------------------------------------------------------------
module tmcw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic           clk,
  input  logic           rst,
  tmcw_in_if.sink        req,
  tmcw_cfg_if.sink       cfg,
  output tmcw_pkg::cmd_t push_cmd,
  output logic           push_valid,
  input  logic           push_ready
);

  localparam int POS_W = $clog2(ROWS + 1);
  localparam logic [POS_W-1:0]          ROW_HIDE = POS_W'(ROWS);
  localparam logic [POS_W-1:0]          ROW_LAST = POS_W'(ROWS - 1);
  localparam logic [tmcw_pkg::COL_W-1:0] COL_LAST = tmcw_pkg::COL_W'(COLUMNS - 1);
  localparam logic [7:0]                COL_LIM  = 8'(COLUMNS);
  localparam logic [7:0]                ROW_LIM  = 8'(ROWS);

  logic [tmcw_pkg::COL_W-1:0]  col_pos, col_next;
  logic [POS_W-1:0]            row_pos, row_next;
  logic [tmcw_pkg::BYTE_W-1:0] text_attr, text_attr_next;
  tmcw_pkg::lead_t             lead_kind, lead_kind_next;
  logic [tmcw_pkg::COL_W-1:0]  left_margin, left_margin_next;
  logic [tmcw_pkg::COL_W-1:0]  margin_col;
  logic                        emit_en;
  logic [tmcw_pkg::BYTE_W-1:0] emit_ch;
  logic                        emit_lf;
  logic                        accept;
  tmcw_pkg::cmd_t              cmd;

  assign req.ready  = push_ready;
  assign push_valid = req.valid;
  assign accept     = req.valid && push_ready;
  assign cfg.ready  = 1'b1;
  assign push_cmd   = cmd;

  assign margin_col = (8'(left_margin) >= COL_LIM) ? COL_LAST : left_margin;
  assign emit_lf    = (emit_ch == tmcw_pkg::CH_LF);

  always_comb begin
    col_next         = col_pos;
    row_next         = row_pos;
    text_attr_next   = text_attr;
    lead_kind_next   = lead_kind;
    left_margin_next = left_margin;
    emit_en          = 1'b0;
    emit_ch          = req.data_byte;
    cmd              = '0;
    cmd.attr         = text_attr;
    case (tmcw_pkg::action_t'(req.action))
      tmcw_pkg::ACT_PUT: begin
        if (lead_kind != tmcw_pkg::LEAD_NONE) begin
          lead_kind_next = tmcw_pkg::LEAD_NONE;
          case (lead_kind)
            tmcw_pkg::LEAD_ESC: text_attr_next = req.data_byte;
            tmcw_pkg::LEAD_D0: begin
              emit_en = 1'b1;
              emit_ch = (req.data_byte == tmcw_pkg::CH_YO_UP) ? tmcw_pkg::CP_YO_UP
                        : req.data_byte - tmcw_pkg::OFS_D0;
            end
            tmcw_pkg::LEAD_D1: begin
              emit_en = 1'b1;
              if (req.data_byte == tmcw_pkg::CH_YO_LOW) begin
                emit_ch = tmcw_pkg::CP_YO_LOW;
              end else if (req.data_byte < tmcw_pkg::D1_SPLIT) begin
                emit_ch = req.data_byte + tmcw_pkg::OFS_D1_LOW;
              end else begin
                emit_ch = req.data_byte + tmcw_pkg::OFS_D1_HIGH;
              end
            end
            default: ;
          endcase
        end else if (req.data_byte == tmcw_pkg::CH_LEAD_D0) begin
          lead_kind_next = tmcw_pkg::LEAD_D0;
        end else if (req.data_byte == tmcw_pkg::CH_LEAD_D1) begin
          lead_kind_next = tmcw_pkg::LEAD_D1;
        end else if (req.data_byte == tmcw_pkg::CH_ESC) begin
          lead_kind_next = tmcw_pkg::LEAD_ESC;
        end else if (req.data_byte != tmcw_pkg::CH_NUL) begin
          emit_en = 1'b1;
        end
      end
      tmcw_pkg::ACT_LOCATE: begin
        col_next = (8'(req.col_in) >= COL_LIM) ? COL_LAST : req.col_in;
        row_next = (8'(req.row_in) >= ROW_LIM) ? ROW_HIDE : POS_W'(req.row_in);
      end
      tmcw_pkg::ACT_CLEAR: begin
        cmd.clear        = 1'b1;
        cmd.attr         = req.data_byte;
        col_next         = '0;
        row_next         = '0;
        text_attr_next   = req.data_byte;
        left_margin_next = '0;
        lead_kind_next   = tmcw_pkg::LEAD_NONE;
      end
      tmcw_pkg::ACT_READ: begin
        cmd.rd_cell = (8'(req.col_in) < COL_LIM) && (8'(req.row_in) < ROW_LIM);
        cmd.row     = tmcw_pkg::CELL_ROW_W'(req.row_in);
        cmd.col     = req.col_in;
      end
      default: ;
    endcase

    // Print one character: write the cell, step the cursor, wrap and scroll.
    if (emit_en) begin
      cmd.ch      = emit_ch;
      cmd.row     = tmcw_pkg::CELL_ROW_W'(row_pos);
      cmd.col     = col_pos;
      cmd.wr_cell = (row_pos != ROW_HIDE) && (8'(col_pos) < COL_LIM) && !emit_lf;
      if ((8'(col_pos) + 8'd1 >= COL_LIM) || emit_lf) begin
        col_next = margin_col;
        if (row_pos != ROW_HIDE) begin
          if (row_pos == ROW_LAST) begin
            cmd.scroll = 1'b1;
          end else begin
            row_next = row_pos + POS_W'(1);
          end
        end
      end else begin
        col_next = col_pos + tmcw_pkg::COL_W'(1);
      end
    end

    cmd.cur_col = col_next;
    cmd.cur_row = tmcw_pkg::ROW_W'(row_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos     <= '0;
      row_pos     <= '0;
      text_attr   <= tmcw_pkg::ATTR_RESET;
      lead_kind   <= tmcw_pkg::LEAD_NONE;
      left_margin <= '0;
    end else begin
      if (accept) begin
        col_pos     <= col_next;
        row_pos     <= row_next;
        text_attr   <= text_attr_next;
        lead_kind   <= lead_kind_next;
      end
      if (cfg.valid) begin
        left_margin <= cfg.left_margin;
      end else if (accept) begin
        left_margin <= left_margin_next;
      end
    end
  end

endmodule

// ----- rtl/tmcw_queue.sv -----
// ----------------------------------------------------------------------------
// Console writer command queue
// Two-entry FIFO between the front end and the memory sequencer.
// ----------------------------------------------------------------------------
module tmcw_queue (
  input  logic           clk,
  input  logic           rst,
  input  tmcw_pkg::cmd_t push_cmd,
  input  logic           push_valid,
  output logic           push_ready,
  output tmcw_pkg::cmd_t pop_cmd,
  output logic           pop_valid,
  input  logic           pop_ready
);

  tmcw_pkg::cmd_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = slot[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/tmcw_back.sv -----
// ----------------------------------------------------------------------------
// Console writer back end
// Owns the cell memory: cell writes, scroll and clear sweeps, cell reads.
// ----------------------------------------------------------------------------
module tmcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic           clk,
  input  logic           rst,
  input  tmcw_pkg::cmd_t pop_cmd,
  input  logic           pop_valid,
  output logic           pop_ready,
  tmcw_out_if.source     rsp
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_END = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(COLUMNS);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CELL  = 6'b000010,
    ST_SWEEP = 6'b000100,
    ST_READ  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t         state;
  tmcw_pkg::cmd_t cmd;
  logic [ADDR_W-1:0] cnt;
  logic [ADDR_W-1:0] cell_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [15:0]       rd_data;
  logic [15:0]       cell_q;
  logic              pend_v;
  logic              pend_mem;
  logic [ADDR_W-1:0] pend_addr;
  logic [15:0]       pend_data;
  logic              out_v;
  logic              emit_go;
  logic [15:0]       mem [CELLS];

  assign pop_ready = (state == ST_IDLE);
  assign rsp.valid = out_v;
  assign cell_addr = ADDR_W'(32'(cmd.row) * COLUMNS + 32'(cmd.col));
  assign rd_addr   = (state == ST_SWEEP) ? cnt + ROW_STEP : cell_addr;
  // Load the response register once it is empty or being drained.
  assign emit_go   = (state == ST_EMIT) && (!out_v || rsp.ready);

  // Read every cycle; retire the pending write, taking copy data from the read.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (pend_v) begin
      mem[pend_addr] <= pend_mem ? rd_data : pend_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      pend_v <= 1'b0;
      out_v  <= 1'b0;
    end else begin
      // Retire a write set up in the previous cycle.
      pend_v <= (state == ST_CELL) || (state == ST_SWEEP);
      if (emit_go) begin
        out_v <= 1'b1;
      end else if (rsp.ready) begin
        out_v <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            cmd <= pop_cmd;
            cnt <= '0;
            if (pop_cmd.wr_cell) begin
              state <= ST_CELL;
            end else if (pop_cmd.scroll || pop_cmd.clear) begin
              state <= ST_SWEEP;
            end else if (pop_cmd.rd_cell) begin
              state <= ST_READ;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_CELL: begin
          pend_mem  <= 1'b0;
          pend_addr <= cell_addr;
          pend_data <= {cmd.ch, cmd.attr};
          state     <= cmd.scroll ? ST_SWEEP : ST_DRAIN;
        end
        ST_SWEEP: begin
          // Scroll copies each cell from one row down, then blanks the last row.
          pend_mem  <= cmd.scroll && (cnt < COPY_END);
          pend_addr <= cnt;
          pend_data <= {tmcw_pkg::CH_NUL, cmd.attr};
          cnt       <= cnt + ADDR_W'(1);
          if (cnt == LAST_IDX) begin
            state <= ST_DRAIN;
          end
        end
        ST_READ: begin
          state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          cell_q <= rd_data;
          state  <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_go) begin
            rsp.cursor_col <= cmd.cur_col;
            rsp.cursor_row <= cmd.cur_row;
            rsp.cell_char  <= cmd.rd_cell ? cell_q[15:8] : '0;
            rsp.cell_attr  <= cmd.rd_cell ? cell_q[7:0] : '0;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/text_mode_console_writer.sv -----
// ----------------------------------------------------------------------------
// Text-mode console writer
// COLUMNS x ROWS character/attribute screen with cursor and byte decoding.
// ----------------------------------------------------------------------------
// Usage:
//   req  - one request per handshake: put byte, locate, clear, or read cell.
//   rsp  - exactly one response per request, in order: cursor after the
//          request plus the cell contents for a read (zero otherwise).
//   cfg  - left margin write; write it only while no request is in flight.
// Sequencer steps per request (a new command is taken only when idle):
//   locate, or a put byte that prints nothing: latch, respond.
//   printing put byte or read: latch, cell access, write retire or read
//   capture, respond.
//   clear, or a put byte that scrolls: a sweep of all COLUMNS*ROWS cells,
//   one cell per cycle through the single write port of the cell memory.
// The front end keeps decoding into a two-entry command queue while the
// memory sequencer is busy; req.ready drops only when the queue is full.
// Reset: cursor home, attribute 0x07, margin 0, no lead byte pending. The
//   screen memory is not swept; issue a clear before reading cells.
// Receiver stall: the response register holds, then the sequencer, then the
//   queue, and finally req.ready falls.
// ----------------------------------------------------------------------------
`include "text_mode_console_writer_macros.svh"

module text_mode_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic      clk,
  input  logic      rst,
  tmcw_in_if.sink   req,
  tmcw_cfg_if.sink  cfg,
  tmcw_out_if.source rsp
);

  // Front-to-queue and queue-to-back command requests.
  tmcw_pkg::cmd_t push_cmd;
  logic           push_valid;
  logic           push_ready;
  tmcw_pkg::cmd_t pop_cmd;
  logic           pop_valid;
  logic           pop_ready;

  // Decode bytes, track cursor, attribute and margin.
  tmcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .cfg        (cfg),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // Decouple decoding from long memory sweeps.
  tmcw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_cmd    (pop_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  // Carry out cell writes, scrolls, clears and reads; register the response.
  tmcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_cmd   (pop_cmd),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .rsp       (rsp)
  );

  // A put byte never both scrolls and clears.
  `TMCW_ASSERT_IMPLY(a_scroll_not_clear, push_valid, !(push_cmd.scroll && push_cmd.clear))
  // Cell writes target a cell inside the grid.
  `TMCW_ASSERT_IMPLY(a_write_in_grid, push_valid && push_cmd.wr_cell, (32'(push_cmd.row) < ROWS) && (32'(push_cmd.col) < COLUMNS))
  // Reported cursor column stays inside the grid.
  `TMCW_ASSERT_IMPLY(a_rsp_col_in_grid, rsp.valid, 32'(rsp.cursor_col) < COLUMNS)
  // An empty queue with nothing pushed stays empty.
  `TMCW_ASSERT_NEXT(a_queue_no_phantom, !pop_valid && !push_valid, !pop_valid)

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Console writer testbench
// Drives put-byte, locate, clear and read requests into the 80x25 console and
// predicts every response from a private copy of the screen, cursor, text
// attribute, pending lead byte and left margin. Responses are checked field by
// field in order. A directed opening covers code mapping, attribute escapes,
// wrap, hidden cursor, scroll and out-of-range accesses. Random phases at
// several margins follow, with bursty input, a patterned receiver stall and
// one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb;
  import tmcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  // Worst case is every request scrolling (one cell per cycle) plus stalls and
  // gaps; this limit leaves several times that margin.
  localparam longint RUN_LIMIT = 150_000_000;

  // --------------------------------------------------------------------------
  // Scoreboard: private screen image and the queue of cursor reports still
  // owed by the block.
  // --------------------------------------------------------------------------
  class console_scoreboard;
    localparam int NCOL  = 80;
    localparam int NLINE = 25;

    typedef struct packed {
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [BYTE_W-1:0] ch;
      logic [BYTE_W-1:0] attr;
    } cursor_report_t;

    logic [7:0]       glyph [NCOL*NLINE];
    logic [7:0]       shade [NCOL*NLINE];
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [7:0]       pen_attr;
    lead_t            lead;
    logic [COL_W-1:0] margin;
    cursor_report_t   awaited [$];
    int               mismatches;

    function new();
      foreach (glyph[i]) begin
        glyph[i] = '0;
        shade[i] = '0;
      end
      cur_col    = '0;
      cur_row    = '0;
      pen_attr   = ATTR_RESET;
      lead       = LEAD_NONE;
      margin     = '0;
      mismatches = 0;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    // Margin past the last column acts as the last column.
    function int wrap_col();
      return (margin >= NCOL) ? NCOL - 1 : int'(margin);
    endfunction

    function void scroll_screen();
      for (int i = 0; i < (NLINE - 1) * NCOL; i++) begin
        glyph[i] = glyph[i + NCOL];
        shade[i] = shade[i + NCOL];
      end
      for (int i = 0; i < NCOL; i++) begin
        glyph[(NLINE - 1) * NCOL + i] = '0;
        shade[(NLINE - 1) * NCOL + i] = pen_attr;
      end
    endfunction

    function void place_glyph(logic [7:0] ch);
      int next_col;
      if (cur_row < NLINE && cur_col < NCOL && ch != CH_LF) begin
        glyph[cur_row * NCOL + cur_col] = ch;
        shade[cur_row * NCOL + cur_col] = pen_attr;
      end
      next_col = cur_col + 1;
      if (next_col >= NCOL || ch == CH_LF) begin
        next_col = wrap_col();
        // Hidden cursor keeps its row; the bottom row scrolls instead of moving.
        if (cur_row < NLINE) begin
          if (cur_row == NLINE - 1) scroll_screen();
          else cur_row = cur_row + 1'b1;
        end
      end
      cur_col = COL_W'(next_col);
    endfunction

    function void take_byte(logic [7:0] b);
      lead_t held;
      held = lead;
      if (held != LEAD_NONE) begin
        lead = LEAD_NONE;
        case (held)
          LEAD_ESC: pen_attr = b;
          LEAD_D0:  place_glyph((b == CH_YO_UP) ? CP_YO_UP : b - OFS_D0);
          default:  place_glyph((b == CH_YO_LOW) ? CP_YO_LOW :
                                (b < D1_SPLIT) ? b + OFS_D1_LOW : b + OFS_D1_HIGH);
        endcase
        return;
      end
      if (b == CH_NUL) return;
      if (b == CH_LEAD_D0) begin
        lead = LEAD_D0;
        return;
      end
      if (b == CH_LEAD_D1) begin
        lead = LEAD_D1;
        return;
      end
      if (b == CH_ESC) begin
        lead = LEAD_ESC;
        return;
      end
      place_glyph(b);
    endfunction

    function void note_request(action_t act, logic [7:0] data, logic [COL_W-1:0] col,
                               logic [ROW_W-1:0] row);
      logic [7:0] rch;
      logic [7:0] rat;
      rch = '0;
      rat = '0;
      case (act)
        ACT_PUT: take_byte(data);
        ACT_LOCATE: begin
          cur_col = (col >= NCOL) ? COL_W'(NCOL - 1) : col;
          cur_row = (row >= NLINE) ? ROW_W'(NLINE) : row;
        end
        ACT_CLEAR: begin
          foreach (glyph[i]) begin
            glyph[i] = '0;
            shade[i] = data;
          end
          cur_col  = '0;
          cur_row  = '0;
          pen_attr = data;
          margin   = '0;
          lead     = LEAD_NONE;
        end
        default: begin
          if (col < NCOL && row < NLINE) begin
            rch = glyph[row * NCOL + col];
            rat = shade[row * NCOL + col];
          end
        end
      endcase
      awaited.push_back('{cur_col, cur_row, rch, rat});
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_response(logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                        logic [7:0] ch, logic [7:0] attr);
      cursor_report_t want;
      string diff;
      if (awaited.size() == 0) begin
        report("response with no request outstanding");
        return;
      end
      want = awaited.pop_front();
      diff = "";
      if (col !== want.col)   diff = {diff, $sformatf(" col %0d/%0d", col, want.col)};
      if (row !== want.row)   diff = {diff, $sformatf(" row %0d/%0d", row, want.row)};
      if (ch !== want.ch)     diff = {diff, $sformatf(" char %02h/%02h", ch, want.ch)};
      if (attr !== want.attr) diff = {diff, $sformatf(" attr %02h/%02h", attr, want.attr)};
      if (diff != "") report({"response fields (got/want):", diff});
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels and the block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst;

  tmcw_in_if  req_if ();
  tmcw_cfg_if cfg_if ();
  tmcw_out_if rsp_if ();

  text_mode_console_writer #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .cfg (cfg_if),
    .rsp (rsp_if)
  );

  console_scoreboard sb = new();

  int burst_left    = 0;   // requests left in the current sender burst
  int sent_requests = 0;   // accepted requests so far

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops a response.
  initial begin
    #(RUN_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one request and hold it until accepted. A burst ends by dropping
  // valid in the accepting step; the next request then waits out a gap first.
  task automatic send_request(input action_t act, input logic [7:0] data,
                              input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 8)) @(posedge clk);
      // Mostly short bursts, sometimes a long gap-free stretch.
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
    end
    req_if.valid     <= 1'b1;
    req_if.action    <= act;
    req_if.data_byte <= data;
    req_if.col_in    <= col;
    req_if.row_in    <= row;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(act, data, col, row);
    sent_requests++;
    burst_left--;
    if (burst_left == 0) req_if.valid <= 1'b0;
  endtask

  // Put a byte with junk in the unused position fields.
  task automatic put_byte(input logic [7:0] b);
    send_request(ACT_PUT, b, COL_W'($urandom), ROW_W'($urandom));
  endtask

  // Drop valid, let every owed response arrive, then let the pipeline settle.
  task automatic drain_console();
    if (burst_left != 0) begin
      req_if.valid <= 1'b0;
      burst_left = 0;
    end
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Margin write; only called with the block idle.
  task automatic write_margin(input logic [COL_W-1:0] m);
    cfg_if.valid       <= 1'b1;
    cfg_if.left_margin <= m;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.margin = m;
  endtask

  // One random step: mostly text and well-formed lead sequences, with cursor
  // moves, reads, raw noise bytes and the odd clear mixed in.
  task automatic send_random_item();
    int pick;
    logic [7:0] follow;
    logic [COL_W-1:0] c;
    logic [ROW_W-1:0] r;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      put_byte(8'($urandom_range(8'h20, 8'h7E)));
    end else if (pick < 48) begin
      put_byte(CH_LF);
    end else if (pick < 58) begin
      // Cyrillic pair: special yo codes, the usual continuation range, or any byte.
      case ($urandom_range(0, 3))
        0:       follow = $urandom_range(0, 1) ? CH_YO_UP : CH_YO_LOW;
        1:       follow = 8'($urandom);
        default: follow = 8'($urandom_range(8'h80, 8'hBF));
      endcase
      put_byte($urandom_range(0, 1) ? CH_LEAD_D1 : CH_LEAD_D0);
      put_byte(follow);
    end else if (pick < 63) begin
      put_byte(CH_ESC);
      put_byte(8'($urandom));
    end else if (pick < 70) begin
      // Noise: any byte, including stray leads and zero.
      put_byte(8'($urandom));
    end else if (pick < 81) begin
      c = ($urandom_range(0, 6) == 0) ? COL_W'($urandom_range(COLUMNS, 127))
                                      : COL_W'($urandom_range(0, COLUMNS - 1));
      case ($urandom_range(0, 9))
        0:       r = ROW_W'($urandom_range(ROWS, 31));
        1, 2, 3: r = ROW_W'($urandom_range(ROWS - 3, ROWS - 1));
        default: r = ROW_W'($urandom_range(0, ROWS - 1));
      endcase
      send_request(ACT_LOCATE, 8'($urandom), c, r);
    end else if (pick < 98) begin
      c = ($urandom_range(0, 9) == 0) ? COL_W'($urandom_range(COLUMNS, 127))
                                      : COL_W'($urandom_range(0, COLUMNS - 1));
      r = ($urandom_range(0, 9) == 0) ? ROW_W'($urandom_range(ROWS, 31))
                                      : ROW_W'($urandom_range(0, ROWS - 1));
      send_request(ACT_READ, 8'($urandom), c, r);
    end else begin
      send_request(ACT_CLEAR, 8'($urandom), COL_W'($urandom), ROW_W'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: a stall pattern picked at random from four modes, plus one
  // long hold-off once enough traffic has gone in, so the command queue fills
  // and req.ready falls while the sender keeps offering.
  // --------------------------------------------------------------------------
  int rx_phase        = 0;
  int rx_mode         = 0;
  int hold_left       = 0;
  bit long_hold_done  = 1'b0;

  always @(posedge clk) begin
    rx_phase++;
    if (rx_phase % 256 == 0) rx_mode = $urandom_range(0, 3);
    if (!long_hold_done && sent_requests >= 250) begin
      hold_left      = 400;
      long_hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       rsp_if.ready <= 1'b1;
        1:       rsp_if.ready <= (rx_phase % 7) < 5;
        2:       rsp_if.ready <= 1'($urandom_range(0, 1));
        default: rsp_if.ready <= (rx_phase % 32) > 20;
      endcase
    end
  end

  // Check every response the block hands over.
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready)
      sb.check_response(rsp_if.cursor_col, rsp_if.cursor_row,
                        rsp_if.cell_char, rsp_if.cell_attr);
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [COL_W-1:0] phase_margin [5];
    int phase_start;
    phase_margin = '{7'd79, 7'd127, 7'd0, 7'd40, 7'd0};
    phase_margin[4] = COL_W'($urandom);

    rst                <= 1'b1;
    req_if.valid       <= 1'b0;
    req_if.action      <= ACT_PUT;
    req_if.data_byte   <= '0;
    req_if.col_in      <= '0;
    req_if.row_in      <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.left_margin <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed opening. Clear first: the screen is undefined until then.
    write_margin(7'd5);
    send_request(ACT_CLEAR, 8'h1F, 7'd0, 5'd0);
    drain_console();
    write_margin(7'd3);

    put_byte(8'h41);
    send_request(ACT_READ, 8'h00, 7'd0, 5'd0);
    put_byte(CH_NUL);                  // ignored with no lead pending
    put_byte(CH_ESC);
    put_byte(CH_NUL);                  // attribute becomes zero
    put_byte(CH_ESC);
    put_byte(8'hFF);
    put_byte(CH_LEAD_D0);
    put_byte(CH_YO_UP);
    put_byte(CH_LEAD_D1);
    put_byte(CH_YO_LOW);
    put_byte(CH_LEAD_D1);
    put_byte(8'hB5);                   // upper half of the second lead's range
    put_byte(CH_LEAD_D0);
    put_byte(8'h1A);                   // maps to a line feed
    // Wrap past the last column back to the margin.
    send_request(ACT_LOCATE, 8'h00, 7'd79, 5'd0);
    put_byte(8'h5A);
    // Out-of-range locate hides the cursor at the last column; put only wraps the column to the margin.
    send_request(ACT_LOCATE, 8'hFF, 7'd127, 5'd31);
    put_byte(8'h68);
    send_request(ACT_READ, 8'hFF, 7'd127, 5'd31);
    // Line feed on the bottom row scrolls.
    send_request(ACT_LOCATE, 8'h00, 7'd0, 5'd24);
    put_byte(CH_LF);
    // Locate and read leave a pending lead in place.
    put_byte(CH_LEAD_D0);
    send_request(ACT_LOCATE, 8'h00, 7'd10, 5'd5);
    send_request(ACT_READ, 8'h00, 7'd10, 5'd23);
    put_byte(CH_YO_LOW);
    send_request(ACT_READ, 8'h00, 7'd10, 5'd5);
    drain_console();

    // Random phases, one margin setting each.
    foreach (phase_margin[p]) begin
      write_margin(phase_margin[p]);
      phase_start = sent_requests;
      while (sent_requests - phase_start < 115) send_random_item();
      drain_console();
    end

    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
